[sv/json_string_escape_encoder_unit_assert.svh]
// Assertion macros for the JSON string escape encoder.
// Included by the top level; it depends on nothing else.
`ifndef JSON_STRING_ESCAPE_ENCODER_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPE_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jse assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jse assertion failed");

`endif

[sv/jse_pkg.sv]
// Shared types, character constants and byte functions of the JSON string escape encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package jse_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_HEX_ALPHA_BASE = 8'h57;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  localparam logic [7:0] CC_BS = 8'h08;
  localparam logic [7:0] CC_TAB = 8'h09;
  localparam logic [7:0] CC_LF = 8'h0A;
  localparam logic [7:0] CC_FF = 8'h0C;
  localparam logic [7:0] CC_CR = 8'h0D;

  localparam logic [2:0] ESC_LEN_PLAIN = 3'd1;
  localparam logic [2:0] ESC_LEN_SHORT = 3'd2;
  localparam logic [2:0] ESC_LEN_UNI   = 3'd6;
  localparam logic [3:0] NULL_COUNT    = 4'd4;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI,
    KIND_NULL
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] tag;
    logic       first;
    logic       last;
    logic [2:0] esc_len;
    logic [3:0] count;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] base;
    base = (v < 4'd10) ? CH_ZERO : CH_HEX_ALPHA_BASE;
    return base + {4'b0000, v};
  endfunction

  function automatic logic [7:0] null_char(input logic [1:0] p);
    logic [7:0] c;
    unique case (p)
      2'd0:    c = CH_N;
      2'd1:    c = CH_U;
      default: c = CH_L;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] esc_char(input desc_t d, input logic [2:0] q);
    logic [7:0] c;
    c = d.data;
    unique case (d.kind)
      KIND_SHORT: c = (q == 3'd0) ? CH_BSLASH : d.tag;
      KIND_UNI: begin
        unique case (q)
          3'd0:    c = CH_BSLASH;
          3'd1:    c = CH_U;
          3'd4:    c = hex_char(d.data[7:4]);
          3'd5:    c = hex_char(d.data[3:0]);
          default: c = CH_ZERO;
        endcase
      end
      default: c = d.data;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] item_byte(input desc_t d, input logic [2:0] p);
    logic [2:0] q;
    logic [7:0] c;
    q = p - {2'b00, d.first};
    if (d.kind == KIND_NULL) begin
      c = null_char(p[1:0]);
    end else if (d.first && (p == 3'd0)) begin
      c = CH_QUOTE;
    end else if (q < d.esc_len) begin
      c = esc_char(d, q);
    end else begin
      c = CH_QUOTE;
    end
    return c;
  endfunction

endpackage

[sv/jse_front.sv]
// Front end: classifies each input transaction into an escape descriptor.
// Depends on jse_pkg.
module jse_front import jse_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       is_first,
  input  logic       is_last,
  input  logic       is_null,
  output desc_t      desc,
  output logic       has_output
);

  logic [7:0] tag;
  logic [2:0] esc_len;
  kind_t      kind;

  always_comb begin
    unique case (data_byte)
      CH_QUOTE:  tag = CH_QUOTE;
      CH_BSLASH: tag = CH_BSLASH;
      CC_BS:     tag = CH_B;
      CC_FF:     tag = CH_F;
      CC_LF:     tag = CH_N;
      CC_CR:     tag = CH_R;
      CC_TAB:    tag = CH_T;
      default:   tag = 8'h00;
    endcase

    if (is_null) begin
      kind = KIND_NULL;
    end else if (tag != 8'h00) begin
      kind = KIND_SHORT;
    end else if (data_byte < CTRL_LIMIT) begin
      kind = KIND_UNI;
    end else begin
      kind = KIND_PLAIN;
    end

    if (!has_byte || is_null) begin
      esc_len = 3'd0;
    end else begin
      unique case (kind)
        KIND_SHORT: esc_len = ESC_LEN_SHORT;
        KIND_UNI:   esc_len = ESC_LEN_UNI;
        default:    esc_len = ESC_LEN_PLAIN;
      endcase
    end

    desc.kind    = kind;
    desc.data    = data_byte;
    desc.tag     = tag;
    desc.first   = is_first;
    desc.last    = is_last;
    desc.esc_len = esc_len;
    desc.count   = is_null ? NULL_COUNT
                 : ({3'b000, is_first} + {1'b0, esc_len} + {3'b000, is_last});
    has_output   = (desc.count != 4'd0);
  end

endmodule

[sv/jse_queue.sv]
// Short descriptor queue that decouples the front end from the back end.
// Depends on jse_pkg.
module jse_queue import jse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  desc_t     wr_data,
  input  logic      pop,
  output desc_t     rd_data,
  output q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data      = mem_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_W'(DEPTH));

endmodule

[sv/jse_back.sv]
// Back end: walks the bytes of the head descriptor into a registered output stage.
// Depends on jse_pkg.
module jse_back import jse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  desc_t     head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_byte,
  output logic      out_run_last,
  output logic      out_string_end
);

  logic [2:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       run_last_r, run_last_nxt;
  logic       end_r, end_nxt;
  logic       load;
  logic       last_step;

  always_comb begin
    load      = !q_stat.empty && (!valid_r || out_ready);
    last_step = (({1'b0, step_r} + 4'd1) == head.count);
    pop       = load && last_step;

    step_nxt     = step_r;
    valid_nxt    = valid_r && !out_ready;
    byte_nxt     = byte_r;
    run_last_nxt = run_last_r;
    end_nxt      = end_r;
    if (load) begin
      step_nxt     = last_step ? 3'd0 : step_r + 3'd1;
      valid_nxt    = 1'b1;
      byte_nxt     = item_byte(head, step_r);
      run_last_nxt = last_step;
      end_nxt      = last_step && ((head.kind == KIND_NULL) || head.last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    run_last_r <= run_last_nxt;
    end_r      <= end_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_string_end = end_r;

endmodule

[sv/json_string_escape_encoder_unit.sv]
// JSON string escape encoder, top level: front end, descriptor queue and back end.
// Depends on jse_pkg, jse_front, jse_queue, jse_back and the assertion header.
//
// Usage:
// The in_ channel carries one string byte per transaction in in_tdata, with
// in_tuser flags has_byte, is_first and is_null and in_tlast marking the end
// of the string. The out_ channel returns one byte of escaped JSON text per
// transaction; out_tlast marks the last byte caused by one input transaction
// and out_tuser marks the final byte of the whole JSON string.
// The first result byte of a transaction is registered in the descriptor queue
// and then in the back end's output register before it is valid.
// Throughput: a transaction produces up to eight result bytes, and the back end
// emits them while out_tready is high, so plain bytes stream at one per cycle
// unless the receiver stalls; the back end's single output register sets this rate.
// A transaction that produces no result is accepted and dropped.
// Reset empties the queue and the output register; nothing else is held.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and in_tready falls once the queue is full.
`include "json_string_escape_encoder_unit_assert.svh"

module json_string_escape_encoder_unit import jse_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [2:0] in_tuser,   // [0] has_byte, [1] is_first, [2] is_null
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] string_end
  output logic       out_tlast   // run_last
);

  desc_t     front_desc;
  logic      front_has_output;
  desc_t     head;
  q_status_t q_stat;
  logic      push;
  logic      pop;

  jse_front u_front (
    .data_byte  (in_tdata),
    .has_byte   (in_tuser[0]),
    .is_first   (in_tuser[1]),
    .is_last    (in_tlast),
    .is_null    (in_tuser[2]),
    .desc       (front_desc),
    .has_output (front_has_output)
  );

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready && front_has_output;

  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (front_desc),
    .pop     (pop),
    .rd_data (head),
    .status  (q_stat)
  );

  jse_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_run_last   (out_tlast),
    .out_string_end (out_tuser[0])
  );

  `JSE_ASSERT_SAME(a_end_is_run_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)
  `JSE_ASSERT_NEXT(a_run_continues, clk, rst_n, out_tvalid && !out_tlast, out_tvalid)
  `JSE_ASSERT_NEXT(a_push_fills, clk, rst_n, push, !q_stat.empty)

endmodule
